[rtl/core/utr_pkg.sv]
package utr_pkg;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_STEP_TIME  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_POSE_COUNT = 2'd1;

    localparam logic [15:0] DEFAULT_DT     = 16'd6554;
    localparam logic [6:0]  POSE_COUNT_RST = 7'd11;
    localparam logic [6:0]  MAX_POSES      = 7'd64;

    // Stream payload widths.
    localparam int IN_DW  = 40;
    localparam int OUT_DW = 104;

    // Serial multiplier: 32-bit signed multiplicand, 32-bit multiplier.
    localparam int MUL_W = 32;

    // Rotation datapath: Q2.30 with guard bits, binary angle with one guard bit.
    localparam int XW       = 34;
    localparam int ZW       = 33;
    localparam int ATAN_LEN = 24;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Arctangent of 2^-i as a binary angle, 2^32 per turn.
    localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

    typedef struct packed {
        logic                    busy;
        logic [MUL_W:0]          hi;
        logic [MUL_W-1:0]        lo;
    } t_mul_out;

    typedef struct packed {
        logic                    busy;
        logic [31:0]             cos_q;
        logic [31:0]             sin_q;
    } t_trig_out;

endpackage

[rtl/core/utr_mul.sv]
// Radix-4 Booth multiplier, two multiplier bits per cycle. The partial product
// shifts right two bits a cycle and the bits it drops fill the multiplier
// register, so that {hi, lo} holds the full signed product when busy falls.
module utr_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [utr_pkg::MUL_W-1:0]    i_mcand,
    input  logic [utr_pkg::MUL_W-1:0]    i_mplier,
    output utr_pkg::t_mul_out            o_mul
);
    import utr_pkg::*;

    localparam int STEPS = MUL_W / 2;
    localparam int CW    = $clog2(STEPS);
    localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [MUL_W-1:0] r_m;
    logic [MUL_W:0]   r_hi;
    logic [MUL_W-1:0] r_lo;
    logic             r_prev;

    logic [MUL_W+1:0] m1;
    logic [MUL_W+1:0] m2;
    logic [MUL_W+1:0] addend;
    logic [MUL_W+1:0] sum;
    logic [MUL_W:0]   n_hi;
    logic [MUL_W-1:0] n_lo;

    always_comb begin
        m1 = {{2{r_m[MUL_W-1]}}, r_m};
        m2 = {r_m[MUL_W-1], r_m, 1'b0};
        unique case ({r_lo[1:0], r_prev}) inside
            3'b001, 3'b010: addend = m1;
            3'b011:         addend = m2;
            3'b100:         addend = -m2;
            3'b101, 3'b110: addend = -m1;
            default:        addend = '0;
        endcase
        sum  = {r_hi[MUL_W], r_hi} + addend;
        n_hi = {sum[MUL_W+1], sum[MUL_W+1:2]};
        n_lo = {sum[1:0], r_lo[MUL_W-1:2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= i_mcand;
            r_hi   <= '0;
            r_lo   <= i_mplier;
            r_prev <= 1'b0;
        end else if (r_busy) begin
            r_hi   <= n_hi;
            r_lo   <= n_lo;
            r_prev <= r_lo[1];
        end
    end

    assign o_mul = '{busy: r_busy, hi: r_hi, lo: r_lo};

endmodule

[rtl/core/utr_cordic.sv]
// Rotation-mode sine and cosine, one micro-rotation per cycle. Angles outside
// the right half plane are turned by half a turn first and the results negated.
module utr_cordic #(
    parameter int ITER = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_angle,
    output utr_pkg::t_trig_out   o_trig
);
    import utr_pkg::*;

    localparam int CW = (ITER > 1) ? $clog2(ITER) : 1;
    localparam logic [CW-1:0] LAST = CW'(ITER - 1);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_neg;

    logic                 n_neg;
    logic [31:0]          ang_rot;
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [ZW-1:0] atan_v;
    logic [XW-1:0]        x_out;
    logic [XW-1:0]        y_out;

    always_comb begin
        // Adding a quarter turn sets the top bit exactly for the left half plane.
        n_neg   = i_angle[31] ^ i_angle[30];
        ang_rot = {i_angle[31] ^ n_neg, i_angle[30:0]};
        sx      = r_x >>> r_cnt;
        sy      = r_y >>> r_cnt;
        atan_v  = ATAN_TAB[5'(r_cnt)];
        x_out   = r_neg ? -r_x : r_x;
        y_out   = r_neg ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= {ang_rot[31], ang_rot};
            r_neg <= n_neg;
        end else if (r_busy) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + atan_v;
            end
        end
    end

    assign o_trig = '{busy: r_busy, cos_q: x_out[31:0], sin_q: y_out[31:0]};

endmodule

[rtl/core/unicycle_trajectory_rollout_top.sv]
// Channel    Direction  Transfer carries
// s_axis     in         tdata: lin_speed[15:0], turn_rate[39:16]
// m_axis     out        tdata: out_x, out_y, quat_z, quat_w, pose_number, pad; tlast: last
// i_cfg      in         write of step_time (index 0) or pose_count (index 1)
//
// One command first forms v*dt and the heading step, then runs the rotations for its first
// pose, then the rotations and position products for each further pose; the loop is set by
// the rotation units and the serial multipliers, which work side by side.
// Reset is synchronous and active low; it restores both registers to their defaults and drops
// all valids. A stalled m_axis only holds the pose loop; s_axis is ready whenever no rollout is
// under way, even while the final pose still waits for its transfer.
module unicycle_trajectory_rollout_top #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, from bit 0 up: lin_speed (16), turn_rate (24)
    input  logic [utr_pkg::IN_DW-1:0]     s_axis_tdata,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, from bit 0 up: out_x (32), out_y (32), quat_z (16), quat_w (16),
    // pose_number (6), two zero bits
    output logic [utr_pkg::OUT_DW-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,

    input  logic                          i_cfg_we,
    input  logic [utr_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [utr_pkg::CFG_DW-1:0]    i_cfg_wdata
);
    import utr_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;   // waiting for a command
    localparam logic [1:0] S_PREP  = 2'd1;   // forming v*dt and rate*dt
    localparam logic [1:0] S_ROUND = 2'd2;   // rotations and position products running
    localparam logic [1:0] S_EMIT  = 2'd3;   // handing the pose to the output register

    logic [1:0]  r_state;
    logic [15:0] r_step_time;
    logic [6:0]  r_pose_count;

    // Rollout datapath.
    logic [6:0]  r_n;
    logic [5:0]  r_k;
    logic [31:0] r_vdt;
    logic [31:0] r_inc;
    logic [31:0] r_head;
    logic [31:0] r_acc_x;
    logic [31:0] r_acc_y;
    logic        r_mul_on;

    // Output register.
    logic        r_ovalid;
    logic [31:0] r_out_x;
    logic [31:0] r_out_y;
    logic [15:0] r_qz;
    logic [15:0] r_qw;
    logic [5:0]  r_pose;
    logic        r_last;

    t_mul_out    mul_a;
    t_mul_out    mul_b;
    t_trig_out   trig_h;
    t_trig_out   trig_c;

    logic [15:0] dt_eff;
    logic [6:0]  n_clamp;
    logic        accept_in;
    logic        units_idle;
    logic        out_free;
    logic        last_pose;
    logic        prep_done;
    logic        round_done;
    logic        emit_go;
    logic        mul_start;
    logic        trig_start;
    logic [31:0] n_head;
    logic [31:0] trig_angle;
    logic [31:0] half_angle;
    logic [31:0] mcand_a;
    logic [31:0] mcand_b;
    logic [31:0] mplier_a;
    logic [31:0] mplier_b;
    logic [22:0] d_x;
    logic [22:0] d_y;
    logic [32:0] sum_x;
    logic [32:0] sum_y;

    // Clamp a 33-bit sum to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return s[31:0];
    endfunction

    // Q2.30 to Q1.15 with rounding half up, saturated.
    function automatic logic [15:0] to_q15(input logic [31:0] v);
        logic [32:0] t;
        logic [17:0] q;
        t = {v[31], v} + 33'd16384;
        q = t[32:15];
        if (q[17] && !(&q[16:15])) begin
            return 16'h8000;
        end
        if (!q[17] && (|q[16:15])) begin
            return 16'h7fff;
        end
        return q[15:0];
    endfunction

    always_comb begin
        dt_eff     = (r_step_time == '0) ? DEFAULT_DT : r_step_time;
        if (r_pose_count == '0) begin
            n_clamp = 7'd1;
        end else if (r_pose_count > MAX_POSES) begin
            n_clamp = MAX_POSES;
        end else begin
            n_clamp = r_pose_count;
        end

        accept_in  = s_axis_tvalid && s_axis_tready;
        units_idle = !mul_a.busy && !mul_b.busy && !trig_h.busy && !trig_c.busy;
        out_free   = !r_ovalid || m_axis_tready;
        last_pose  = ({1'b0, r_k} + 7'd1) == r_n;
        prep_done  = (r_state == S_PREP) && units_idle;
        round_done = (r_state == S_ROUND) && units_idle;
        emit_go    = (r_state == S_EMIT) && out_free;

        // The heading step is constant over a rollout, so the next pose's
        // rotations start while this pose's position products are formed.
        n_head     = r_head + r_inc;
        mul_start  = accept_in || (emit_go && !last_pose);
        trig_start = prep_done || (emit_go && !last_pose);
        trig_angle = prep_done ? '0 : n_head;
        half_angle = {trig_angle[31], trig_angle[31:1]};

        // While idle the multipliers take v*dt and rate*dt from the command;
        // afterwards they scale cos and sin of the heading by v*dt.
        if (r_state == S_IDLE) begin
            mcand_a  = {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
            mcand_b  = {{8{s_axis_tdata[39]}}, s_axis_tdata[39:16]};
            mplier_a = {16'd0, dt_eff};
            mplier_b = {16'd0, dt_eff};
        end else begin
            mcand_a  = r_vdt;
            mcand_b  = r_vdt;
            mplier_a = trig_c.cos_q;
            mplier_b = trig_c.sin_q;
        end

        // Position step is the product shifted down by 42 bits; the
        // multiplier already dropped 32 of them.
        d_x   = mul_a.hi[32:10];
        d_y   = mul_b.hi[32:10];
        sum_x = {r_acc_x[31], r_acc_x} + {{10{d_x[22]}}, d_x};
        sum_y = {r_acc_y[31], r_acc_y} + {{10{d_y[22]}}, d_y};
    end

    utr_mul u_mul_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mcand_a),
        .i_mplier (mplier_a),
        .o_mul    (mul_a)
    );

    utr_mul u_mul_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mcand_b),
        .i_mplier (mplier_b),
        .o_mul    (mul_b)
    );

    // Half heading feeds the quaternion, full heading the position step.
    utr_cordic #(
        .ITER (TRIG_ITERATIONS)
    ) u_trig_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (half_angle),
        .o_trig  (trig_h)
    );

    utr_cordic #(
        .ITER (TRIG_ITERATIONS)
    ) u_trig_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (trig_angle),
        .o_trig  (trig_c)
    );

    // Control: sequencer, configuration registers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_time  <= DEFAULT_DT;
            r_pose_count <= POSE_COUNT_RST;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_STEP_TIME:  r_step_time  <= i_cfg_wdata;
                    REG_POSE_COUNT: r_pose_count <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end

            // A new pose may replace the one leaving in the same cycle.
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (prep_done) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (round_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_state <= last_pose ? S_IDLE : S_ROUND;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: rollout state and the pose held for the output transfer.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_n <= n_clamp;
        end

        if (prep_done) begin
            r_vdt    <= mul_a.lo;
            r_inc    <= {mul_b.hi[3:0], mul_b.lo[31:4]};
            r_head   <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_k      <= '0;
            r_mul_on <= 1'b0;
        end

        if (round_done && r_mul_on) begin
            r_acc_x <= sat32(sum_x);
            r_acc_y <= sat32(sum_y);
        end

        if (emit_go) begin
            r_out_x <= r_acc_x;
            r_out_y <= r_acc_y;
            r_qz    <= to_q15(trig_h.sin_q);
            r_qw    <= to_q15(trig_h.cos_q);
            r_pose  <= r_k;
            r_last  <= last_pose;
            if (!last_pose) begin
                r_head   <= n_head;
                r_k      <= r_k + 1'b1;
                r_mul_on <= 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_pose, r_qw, r_qz, r_out_y, r_out_x};
    assign m_axis_tlast  = r_last;

endmodule

[rtl/core/utr_checker.sv]
module utr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [utr_pkg::OUT_DW-1:0]   m_axis_tdata,
    input logic                         m_axis_tlast
);
    import utr_pkg::*;

    logic       out_xfer;
    logic [5:0] r_exp;
    logic [5:0] n_exp;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign n_exp    = m_axis_tlast ? 6'd0 : m_axis_tdata[101:96] + 6'd1;

    // Expected pose number of the next output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (out_xfer) begin
            r_exp <= n_exp;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("pose changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken during a rollout");

    a_pose_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> m_axis_tdata[101:96] == r_exp)
        else $error("pose number out of sequence");

    a_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && m_axis_tdata[101:96] == 6'd0 |-> m_axis_tdata[63:0] == 64'd0)
        else $error("rollout does not start at the origin");

endmodule

bind unicycle_trajectory_rollout_top utr_checker u_utr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/rollout_checker.sv]
`timescale 1ns / 100ps

module rollout_checker #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // tdata, from bit 0 up: lin_speed (16), turn_rate (24)
    input  logic [utr_pkg::IN_DW-1:0]     s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, from bit 0 up: out_x (32), out_y (32), quat_z (16), quat_w (16),
    // pose_number (6), two zero bits
    input  logic [utr_pkg::OUT_DW-1:0]    m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [utr_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [utr_pkg::CFG_DW-1:0]    i_cfg_wdata,
    output int                            o_failures,
    output int                            o_outstanding
);
    import utr_pkg::*;

    localparam longint      START_X    = 64'sd652032874;
    localparam longint      POS_MAX    = 64'sd2147483647;
    localparam longint      POS_MIN    = -64'sd2147483648;
    localparam logic [15:0] NOMINAL_DT = 16'd6554;
    localparam logic [6:0]  COUNT_RST  = 7'd11;
    localparam int          POSE_LIMIT = 64;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] qz;
        logic [15:0] qw;
        logic [5:0]  idx;
        logic [1:0]  pad;
        logic        is_last;
    } t_pose;

    t_pose       expected_poses[$];
    logic [15:0] step_time;
    logic [6:0]  pose_count;
    int          failures = 0;

    // Arctangent of 2^-i as a binary angle, one turn = 2^32.
    function automatic longint arctan_step(input int i);
        case (i)
            0:  return 536870912;   1:  return 316933406;   2:  return 167458907;
            3:  return 85004756;    4:  return 42667331;    5:  return 21354465;
            6:  return 10679838;    7:  return 5340245;     8:  return 2670163;
            9:  return 1335087;     10: return 667544;      11: return 333772;
            12: return 166886;      13: return 83443;       14: return 41722;
            15: return 20861;       16: return 10430;       17: return 5215;
            18: return 2608;        19: return 1304;        20: return 652;
            21: return 326;         22: return 163;         23: return 81;
            default: return 0;
        endcase
    endfunction

    // Rotation-mode CORDIC, Q2.30 out. Angles outside the right half plane are
    // turned by half a turn and the results negated.
    function automatic void cordic_rotate(input logic [31:0] angle,
                                          output longint c, output longint s);
        logic [31:0] a;
        logic [31:0] probe;
        bit          flip;
        longint      x, y, z, nx;
        int          i;
        a = angle;
        probe = a + 32'h4000_0000;
        flip = probe[31];
        if (flip) a = a + 32'h8000_0000;
        x = START_X;
        y = 0;
        z = longint'($signed(a));
        for (i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arctan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arctan_step(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [15:0] to_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic void predict_rollout(input logic [IN_DW-1:0] cmd);
        longint      speed, rate, dt, c, s, hc, hs, half, turn, px, py;
        logic [31:0] hdg;
        int          n, k;
        t_pose       p;
        speed = longint'($signed(cmd[15:0]));
        rate  = longint'($signed(cmd[39:16]));
        dt    = (step_time == 16'd0) ? longint'(NOMINAL_DT) : longint'(step_time);
        n     = int'(pose_count);
        if (n < 1) n = 1;
        if (n > POSE_LIMIT) n = POSE_LIMIT;
        px  = 0;
        py  = 0;
        hdg = '0;
        for (k = 0; k < n; k++) begin
            half = longint'($signed(hdg)) >>> 1;
            cordic_rotate(half[31:0], hc, hs);
            p.x       = px[31:0];
            p.y       = py[31:0];
            p.qz      = to_q15(hs);
            p.qw      = to_q15(hc);
            p.idx     = k[5:0];
            p.pad     = 2'b00;
            p.is_last = (k == n - 1);
            expected_poses = {expected_poses, p};
            cordic_rotate(hdg, c, s);
            px   = clamp32(px + ((speed * c * dt) >>> 42));
            py   = clamp32(py + ((speed * s * dt) >>> 42));
            turn = (rate * dt) >>> 4;
            hdg  = hdg + turn[31:0];
        end
    endfunction

    function automatic string describe(input t_pose p);
        return $sformatf("x=%0d y=%0d z=%0d w=%0d pose=%0d pad=%0d last=%0d",
                         $signed(p.x), $signed(p.y), $signed(p.qz), $signed(p.qw),
                         p.idx, p.pad, p.is_last);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_pose seen;
        t_pose want;
        if (!i_rst_n) begin
            step_time  = NOMINAL_DT;
            pose_count = COUNT_RST;
            expected_poses.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[79:64],
                        m_axis_tdata[95:80], m_axis_tdata[101:96], m_axis_tdata[103:102],
                        m_axis_tlast};
                if (expected_poses.size() == 0) begin
                    failures++;
                    $display("%0t: expected no pose, actual %s", $time, describe(seen));
                end else begin
                    want = expected_poses.pop_front();
                    if (seen !== want) begin
                        failures++;
                        $display("%0t: expected %s, actual %s",
                                 $time, describe(want), describe(seen));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_rollout(s_axis_tdata);
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_STEP_TIME:  step_time  = i_cfg_wdata;
                    REG_POSE_COUNT: pose_count = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
        end
        o_failures    <= failures;
        o_outstanding <= expected_poses.size();
    end

endmodule

[tb/tb_unicycle_trajectory_rollout_top.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the trajectory rollout block. All prediction and
// comparison lives in rollout_checker; this module only drives the command
// stream, the configuration port and the pose receiver, and decides the end.
module tb_unicycle_trajectory_rollout_top;
    import utr_pkg::*;

    localparam int TRIG_ITERATIONS = 16;
    // The receiver's one long hold-off, long enough for the block to stall its
    // command input behind a blocked pose.
    localparam int RX_HOLD         = 1500;
    // Cycles without any transfer before the run is declared hung. Several
    // times the longest correct quiet stretch (the hold-off above).
    localparam int WATCHDOG_LIMIT  = 10000;
    localparam int RANDOM_PHASES   = 13;
    localparam int PHASE_ITEMS     = 30;
    // Tail after the last expected pose, covering more than one first-pose latency.
    localparam int DRAIN_CYCLES    = 60;
    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_AW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_AW-1:0] REG_SPARE_B = 2'd3;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DW-1:0]     s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr    = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata   = '0;

    int failures;
    int outstanding;
    int idle_cycles = 0;
    bit hold_armed  = 1'b0;
    bit hold_taken  = 1'b0;

    always #10 i_clk = ~i_clk;

    unicycle_trajectory_rollout_top #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) dut (.*);

    rollout_checker #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_rollout_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    // Offer one command and hold it until the transfer happens. With a gap the
    // valid drops and the data is scrambled for that many cycles; without one,
    // valid stays high so the next call can follow back to back.
    task automatic send_command(input logic [IN_DW-1:0] cmd, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DW'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted pose has been transferred.
    // The checker's count settles in the nonblocking region, so it is read on
    // the falling edge.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Writes both registers back to back, optionally followed by writes to the
    // unused indexes, then releases the write enable. Only called while idle.
    task automatic configure(input logic [15:0] dt_word, input logic [15:0] count_word,
                             input bit spare);
        write_reg(REG_STEP_TIME, dt_word);
        write_reg(REG_POSE_COUNT, count_word);
        if (spare) begin
            write_reg(REG_SPARE_A, CFG_DW'($urandom));
            write_reg(REG_SPARE_B, CFG_DW'($urandom));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random command: mostly full-range values, with a share of extremes and of
    // small values so that slow turns and short tracks are covered as well.
    function automatic logic [IN_DW-1:0] random_command();
        logic [15:0] spd;
        logic [23:0] rate;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       spd = 16'h7FFF;
                    1:       spd = 16'h8000;
                    2:       spd = 16'h0000;
                    3:       spd = 16'h0001;
                    default: spd = 16'hFFFF;
                endcase
            end
            1:       spd = 16'($urandom_range(0, 128) - 64);
            default: spd = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       rate = 24'h7FFFFF;
                    1:       rate = 24'h800000;
                    2:       rate = 24'h000000;
                    3:       rate = 24'h000001;
                    default: rate = 24'hFFFFFF;
                endcase
            end
            1:       rate = 24'($urandom_range(0, 8192) - 4096);
            2:       rate = 24'($urandom_range(0, 262144) - 131072);
            default: rate = 24'($urandom);
        endcase
        return {rate, spd};
    endfunction

    // Pose receiver. It alternates between steady stretches, where it is always
    // ready, and choppy ones with mostly short stalls and the odd long one. Once
    // the stimulus arms it, it also makes its one long hold-off in one go.
    initial begin : receiver
        int stall_left;
        int mode_left;
        bit steady;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 400);
                steady    = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Hang detection: any transfer on either stream restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("unicycle_trajectory_rollout_top: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] dt_word;
        logic [15:0] count_word;
        int          gap;
        bit          quiet;
        int          p;
        int          k;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults after reset: a 0.1 s step and eleven poses. The first
        // pose of every rollout has heading zero, where the half-angle cosine is
        // one and has to saturate in the quaternion w field.
        send_command({24'h000000, 16'h0000}, 0);   // standing still
        send_command({24'h000000, 16'h7FFF}, 1);   // fastest forward, straight
        send_command({24'h000000, 16'h8000}, 0);   // fastest reverse, straight
        send_command({24'h7FFFFF, 16'h7FFF}, 2);   // fastest left turn, heading wraps
        send_command({24'h800000, 16'h8000}, 0);   // fastest right turn in reverse
        send_command({24'h000001, 16'h0001}, 0);   // smallest positive values
        send_command({24'hFFFFFF, 16'hFFFF}, 3);   // smallest negative values
        send_command({24'h100000, 16'h1000}, 0);   // one turn per second at 1 m/s
        send_command({24'h040000, 16'h1000}, 0);   // quarter turn per second
        send_command({24'hAAAAAA, 16'h5555}, 0);   // alternating bit patterns
        send_command({24'h555555, 16'hAAAA}, 0);
        drain_results();

        // A zero step selects 0.1 s and a zero pose count means one pose. The
        // unused register indexes are written as well and must be ignored.
        configure(16'h0000, 16'h0000, 1'b1);
        send_command({24'h7FFFFF, 16'h7FFF}, 0);
        send_command({24'h800000, 16'h8000}, 0);
        drain_results();

        // Longest step with the full 64 poses; the upper data bits of the count
        // write lie outside the register.
        configure(16'hFFFF, 16'hFFC0, 1'b0);
        send_command({24'h7FFFFF, 16'h7FFF}, 0);
        send_command({24'h400000, 16'h8000}, 0);
        send_command({24'h800000, 16'h3039}, 0);
        drain_results();

        // Shortest step, and a pose count above the limit that must clamp to 64.
        configure(16'h0001, 16'h007F, 1'b1);
        send_command({24'h7FFFFF, 16'h7FFF}, 0);
        send_command({24'hC00000, 16'h8000}, 0);
        drain_results();

        // Random phases. The first few use fixed register values, mostly extremes;
        // the rest pick the step at random and mostly short rollouts. Phase 0 arms
        // the long receiver hold-off while commands keep coming back to back, and
        // phase 4 waits for every pose before offering the next command.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    dt_word    = 16'd6554;
                    count_word = 16'd8;
                end
                1: begin
                    dt_word    = 16'hFFFF;
                    count_word = 16'd64;
                end
                2: begin
                    dt_word    = 16'h0000;
                    count_word = 16'd1;
                end
                3: begin
                    dt_word    = 16'h0001;
                    count_word = 16'd2;
                end
                default: begin
                    dt_word           = 16'($urandom);
                    count_word        = 16'($urandom);
                    count_word[6:0]   = 7'($urandom_range(1, 16));
                    if ($urandom_range(0, 5) == 0)
                        count_word[6:0] = 7'($urandom_range(0, 127));
                end
            endcase
            configure(dt_word, count_word, (p % 4) == 3);
            quiet = ((p % 3) == 2);
            if (p == 0) hold_armed = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 || quiet) begin
                    gap = 0;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gap = 0;
                        6, 7, 8:          gap = $urandom_range(1, 3);
                        default:          gap = $urandom_range(20, 120);
                    endcase
                end
                send_command(random_command(), gap);
                if (p == 4) drain_results();
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("unicycle_trajectory_rollout_top: match");
        end else begin
            $display("unicycle_trajectory_rollout_top: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/utr_pkg.sv
rtl/core/utr_mul.sv
rtl/core/utr_cordic.sv
rtl/core/unicycle_trajectory_rollout_top.sv
rtl/core/utr_checker.sv
tb/rollout_checker.sv
tb/tb_unicycle_trajectory_rollout_top.sv
